// ----- rtl/bbpcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Page cache directory package
// Shared types and constants for the byte-budget page cache directory.
// ----------------------------------------------------------------------------
package bbpcd_pkg;

    localparam int FILE_W  = 16;
    localparam int PAGE_W  = 32;
    localparam int SIZE_W  = 21;
    localparam int BUDGET_W = 40;
    localparam int BYTES_W = 41;
    localparam int EVICT_W = 7;
    localparam logic [EVICT_W-1:0] EVICT_SAT = 7'd127;

    localparam logic CFG_MAX_BYTES    = 1'b0;
    localparam logic CFG_CACHE_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TRIM   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [FILE_W-1:0] file;
        logic [PAGE_W-1:0] page;
        logic [SIZE_W-1:0] size;
    } t_key;

    typedef struct packed {
        logic valid;
        t_key key;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
    } t_cell_ctl;

endpackage

// ----- rtl/bbpcd_if.sv -----
// ----------------------------------------------------------------------------
// Page cache directory channels
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bbpcd_item_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [bbpcd_pkg::FILE_W-1:0]   file_id;
    logic [bbpcd_pkg::PAGE_W-1:0]   page_id;
    logic [bbpcd_pkg::SIZE_W-1:0]   size_bytes;

    modport source (output valid, opcode, file_id, page_id, size_bytes, input ready);
    modport sink (input valid, opcode, file_id, page_id, size_bytes, output ready);
endinterface

interface bbpcd_result_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [bbpcd_pkg::SIZE_W-1:0]   copy_size;
    logic                           inserted;
    logic [bbpcd_pkg::EVICT_W-1:0]  evicted_count;

    modport source (output valid, hit, copy_size, inserted, evicted_count, input ready);
    modport sink (input valid, hit, copy_size, inserted, evicted_count, output ready);
endinterface

interface bbpcd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic                           index;
    logic [bbpcd_pkg::BUDGET_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bbpcd_cell.sv -----
// ----------------------------------------------------------------------------
// Page cache directory cell
// Holds one entry in insertion order, shifts toward the oldest end on
// eviction and compares its file and page against the request key.
// ----------------------------------------------------------------------------
module bbpcd_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bbpcd_pkg::t_cell_ctl            i_ctl,
    input  bbpcd_pkg::t_key                 i_key,
    input  logic                            i_prev_valid,
    input  bbpcd_pkg::t_entry               i_next,
    output bbpcd_pkg::t_entry               o_entry,
    output logic                            o_match,
    output logic [bbpcd_pkg::SIZE_W-1:0]    o_match_size
);

    logic                         r_valid;
    bbpcd_pkg::t_key              r_key;
    logic                         r_match;
    logic [bbpcd_pkg::SIZE_W-1:0] r_match_size;
    logic                         w_load;
    logic                         w_hit;

    assign w_load = i_ctl.load && !r_valid && i_prev_valid;
    assign w_hit  = r_valid && (r_key.file == i_key.file) && (r_key.page == i_key.page);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctl.shift) begin
                r_valid <= i_next.valid;
            end else if (w_load) begin
                r_valid <= 1'b1;
            end
            r_match <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_next.key;
        end else if (w_load) begin
            r_key <= i_key;
        end
        r_match_size <= w_hit ? r_key.size : '0;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_match       = r_match;
    assign o_match_size  = r_match_size;

endmodule

// ----- rtl/byte_budget_page_cache_directory.sv -----
// ----------------------------------------------------------------------------
// Byte-budget page cache directory
// Metadata directory of a page cache with FIFO eviction under a byte budget.
// ----------------------------------------------------------------------------
// Requests arrive as words on i_item (lookup, insert, trim, clear) and each
// produces exactly one result word on o_result. Registers are written on
// i_cfg: index 0 is the 40-bit byte budget, index 1 the cache enable bit.
// Entries live in a row of cells ordered oldest first; a lookup compares all
// cells in the same cycle and the registered matches are merged in the next.
// A lookup, clear, disabled request or ignored insert passes through the
// search and decide states to the result state; a trim also passes through
// evict, and a new insert through evict and append.
// Eviction removes one entry per cycle by shifting the row of cells.
// A new request is taken only when the previous one has finished. The
// finished result may still sit in the output register, so a stalled
// receiver costs nothing until the next result is ready. Reset empties the
// directory at once, restores the budget to 64 MiB and enables the cache.
// ----------------------------------------------------------------------------
module byte_budget_page_cache_directory #(
    parameter int ENTRIES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bbpcd_item_if.sink     i_item,
    bbpcd_result_if.source o_result,
    bbpcd_cfg_if.sink      i_cfg
);

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_DECIDE = 6'b000100,
        S_EVICT  = 6'b001000,
        S_APPEND = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state                          r_state;
    bbpcd_pkg::t_opcode              r_op;
    bbpcd_pkg::t_key                 r_key;
    logic [CW-1:0]                   r_count;
    logic [bbpcd_pkg::BYTES_W-1:0]   r_bytes;
    logic [bbpcd_pkg::BUDGET_W-1:0]  r_max;
    logic                            r_enable;
    logic                            r_hit;
    logic [bbpcd_pkg::SIZE_W-1:0]    r_copy;
    logic                            r_ins;
    logic [bbpcd_pkg::EVICT_W-1:0]   r_evict;
    logic                            r_out_valid;
    logic                            r_out_hit;
    logic [bbpcd_pkg::SIZE_W-1:0]    r_out_copy;
    logic                            r_out_ins;
    logic [bbpcd_pkg::EVICT_W-1:0]   r_out_evict;

    bbpcd_pkg::t_cell_ctl            w_ctl;
    bbpcd_pkg::t_entry               w_entry [ENTRIES];
    logic                            w_match [ENTRIES];
    logic [bbpcd_pkg::SIZE_W-1:0]    w_msize [ENTRIES];
    logic                            w_any;
    logic [bbpcd_pkg::SIZE_W-1:0]    w_size;
    logic                            w_over_ins;
    logic                            w_over_trim;
    logic                            w_need_evict;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            bbpcd_pkg::t_entry w_next;
            logic              w_prev;
            if (g == ENTRIES - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_entry[g+1];
            end
            if (g == 0) begin : g_first
                assign w_prev = 1'b1;
            end else begin : g_rest
                assign w_prev = w_entry[g-1].valid;
            end
            bbpcd_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (r_key),
                .i_prev_valid (w_prev),
                .i_next       (w_next),
                .o_entry      (w_entry[g]),
                .o_match      (w_match[g]),
                .o_match_size (w_msize[g])
            );
        end
    endgenerate

    always_comb begin
        w_any  = 1'b0;
        w_size = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_any  = w_any | w_match[i];
            w_size = w_size | w_msize[i];
        end
    end

    assign w_over_ins  = (r_bytes + bbpcd_pkg::BYTES_W'(r_key.size))
                         > bbpcd_pkg::BYTES_W'(r_max);
    assign w_over_trim = r_bytes > bbpcd_pkg::BYTES_W'(r_max);
    assign w_need_evict = (r_count != '0) &&
                          ((r_op == bbpcd_pkg::OP_INSERT)
                           ? (w_over_ins || (r_count == CW'(ENTRIES)))
                           : w_over_trim);

    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            S_DECIDE: begin
                w_ctl.clear = r_enable && (r_op == bbpcd_pkg::OP_CLEAR);
            end
            S_EVICT: begin
                w_ctl.shift = w_need_evict;
            end
            S_APPEND: begin
                w_ctl.load = 1'b1;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= 40'd67108864;
            r_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bbpcd_pkg::CFG_MAX_BYTES:    r_max    <= i_cfg.data;
                bbpcd_pkg::CFG_CACHE_ENABLE: r_enable <= i_cfg.data[0];
                default:                     r_enable <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!r_enable) begin
                        r_state <= S_RESULT;
                    end else begin
                        unique case (r_op)
                            bbpcd_pkg::OP_LOOKUP: r_state <= S_RESULT;
                            bbpcd_pkg::OP_INSERT: begin
                                r_state <= ((r_key.size == '0) || w_any) ? S_RESULT : S_EVICT;
                            end
                            bbpcd_pkg::OP_TRIM: r_state <= S_EVICT;
                            bbpcd_pkg::OP_CLEAR: begin
                                r_state <= S_RESULT;
                                r_count <= '0;
                                r_bytes <= '0;
                            end
                            default: r_state <= S_RESULT;
                        endcase
                    end
                end
                S_EVICT: begin
                    if (w_need_evict) begin
                        r_count <= r_count - CW'(1);
                        r_bytes <= r_bytes - bbpcd_pkg::BYTES_W'(w_entry[0].key.size);
                    end else if (r_op == bbpcd_pkg::OP_INSERT) begin
                        r_state <= S_APPEND;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_APPEND: begin
                    r_count <= r_count + CW'(1);
                    r_bytes <= r_bytes + bbpcd_pkg::BYTES_W'(r_key.size);
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op      <= bbpcd_pkg::t_opcode'(i_item.opcode);
                r_key.file <= i_item.file_id;
                r_key.page <= i_item.page_id;
                r_key.size <= i_item.size_bytes;
                r_hit     <= 1'b0;
                r_copy    <= '0;
                r_ins     <= 1'b0;
                r_evict   <= '0;
            end
            S_DECIDE: begin
                if (r_enable && (r_op == bbpcd_pkg::OP_LOOKUP) && w_any) begin
                    r_hit  <= 1'b1;
                    r_copy <= (w_size < r_key.size) ? w_size : r_key.size;
                end
                if (r_enable && (r_op == bbpcd_pkg::OP_CLEAR)) begin
                    r_evict <= (32'(r_count) > 32'(bbpcd_pkg::EVICT_SAT))
                               ? bbpcd_pkg::EVICT_SAT : bbpcd_pkg::EVICT_W'(r_count);
                end
            end
            S_EVICT: begin
                if (w_need_evict && (r_evict != bbpcd_pkg::EVICT_SAT)) begin
                    r_evict <= r_evict + bbpcd_pkg::EVICT_W'(1);
                end
            end
            S_APPEND: begin
                r_ins <= 1'b1;
            end
            S_RESULT: begin
                if (!r_out_valid || o_result.ready) begin
                    r_out_hit   <= r_hit;
                    r_out_copy  <= r_copy;
                    r_out_ins   <= r_ins;
                    r_out_evict <= r_evict;
                end
            end
            default: begin
                r_hit <= r_hit;
            end
        endcase
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.hit           = r_out_hit;
    assign o_result.copy_size     = r_out_copy;
    assign o_result.inserted      = r_out_ins;
    assign o_result.evicted_count = r_out_evict;

endmodule

// ----- rtl/bbpcd_checker.sv -----
// ----------------------------------------------------------------------------
// Page cache directory port checker
// Checks result words and output handshake behavior seen at the ports.
// ----------------------------------------------------------------------------
module bbpcd_checker #(
    parameter int ENTRIES = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_hit,
    input logic [bbpcd_pkg::SIZE_W-1:0]   i_copy_size,
    input logic                           i_inserted,
    input logic [bbpcd_pkg::EVICT_W-1:0]  i_evicted_count
);

    localparam int EVICT_MAX = (ENTRIES < 127) ? ENTRIES : 127;

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_hit) |-> (!i_inserted && (i_evicted_count == '0)))
        else $error("Lookup hit reported together with insert or eviction.");

    a_copy_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_hit) |-> (i_copy_size == '0))
        else $error("Copy size reported without a hit.");

    a_evict_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_evicted_count) <= EVICT_MAX))
        else $error("Eviction count exceeds the number of entries.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_hit)
            && $stable(i_copy_size) && $stable(i_inserted) && $stable(i_evicted_count)))
        else $error("Stalled result word changed.");

endmodule

bind byte_budget_page_cache_directory bbpcd_checker #(.ENTRIES(ENTRIES)) u_bbpcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_hit           (o_result.hit),
    .i_copy_size     (o_result.copy_size),
    .i_inserted      (o_result.inserted),
    .i_evicted_count (o_result.evicted_count)
);
